>>> rtl/hcbe_pkg.sv
package hcbe_pkg;

  localparam int LETTER_W      = 5;
  localparam int MODULUS       = 26;
  localparam int BLOCK_LEN_DEF = 4;
  localparam int COEF_BITS_DEF = 5;
  localparam int MAX_LEN       = 8;
  localparam int MAX_COEF_BITS = 8;
  localparam int CFG_IDX_W     = 3;

  // A full sum stays below 2**16 for every legal block length and coefficient width.
  // Division by 26 uses floor(n * 2520 / 2**16), which is exact or one short.
  localparam int SUM_W       = 16;
  localparam int RECIP       = 2520;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 12;
  localparam int QUO_W       = 12;

  localparam int BLK_Q_DEPTH = 2;
  localparam int OUT_Q_DEPTH = 8;

  localparam int RESET_KEY [4][4] = '{
    '{1, 6, 4, 8},
    '{2, 1, 21, 19},
    '{7, 11, 13, 17},
    '{3, 5, 23, 29}
  };

  // Packs the reset coefficients of one key row at the given coefficient width.
  function automatic logic [MAX_LEN*MAX_COEF_BITS-1:0] reset_row(input int row,
                                                                  input int coef_bits);
    logic [MAX_LEN*MAX_COEF_BITS-1:0] v;
    logic [MAX_COEF_BITS-1:0]         coef;
    logic [MAX_COEF_BITS-1:0]         mask;
    v    = '0;
    mask = MAX_COEF_BITS'((1 << coef_bits) - 1);
    for (int c = 0; c < MAX_LEN; c++) begin
      coef = '0;
      if (row < 4 && c < 4) begin
        coef = MAX_COEF_BITS'(RESET_KEY[row][c]) & mask;
      end
      v[c*coef_bits +: MAX_COEF_BITS] = coef;
    end
    return v;
  endfunction

endpackage

>>> rtl/hill_cipher_block_encrypt.sv
// Channel   Handshake              Payload
// input     push / full            plain_letter
// result    pop / empty            cipher_letter, block_end
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Letters are taken one per cycle unless full; every fourth letter completes a block.
// Blocks wait in the block queue; cipher letters pass s1, s2, s3 into the result queue.
// Unless stalled, the back end makes one cipher letter per cycle: the sustained rate.
// Reset loads the fixed key and empties both queues; cfg_ready is always high.
// A full result queue stalls the back end; a full block queue then holds off the
// fourth letter of the next block.
module hill_cipher_block_encrypt
  import hcbe_pkg::*;
#(
  parameter int BLOCK_LEN = BLOCK_LEN_DEF,
  parameter int COEF_BITS = COEF_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [LETTER_W-1:0]            plain_letter,
  output logic                           empty,
  input  logic                           pop,
  output logic [LETTER_W-1:0]            cipher_letter,
  output logic                           block_end,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [BLOCK_LEN*COEF_BITS-1:0] cfg_data
);

  localparam int BLK_W     = BLOCK_LEN * LETTER_W;
  localparam int OUT_CNT_W = $clog2(OUT_Q_DEPTH + 1);
  localparam int BLK_CNT_W = $clog2(BLK_Q_DEPTH + 1);

  logic                 blk_push;
  logic [BLK_W-1:0]     blk_wdata;
  logic                 blk_full;
  logic                 blk_pop;
  logic [BLK_W-1:0]     blk_rdata;
  logic                 blk_empty;
  logic [BLK_CNT_W-1:0] blk_count;
  logic                 out_push;
  logic [LETTER_W:0]    out_wdata;
  logic                 out_full;
  logic [LETTER_W:0]    out_rdata;
  logic [OUT_CNT_W-1:0] out_count;

  hcbe_front #(
    .BLOCK_LEN(BLOCK_LEN)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .plain_letter (plain_letter),
    .blk_push     (blk_push),
    .blk_data     (blk_wdata),
    .blk_full     (blk_full)
  );

  hcbe_fifo #(
    .WIDTH(BLK_W),
    .DEPTH(BLK_Q_DEPTH)
  ) u_blk_q (
    .clk   (clk),
    .rst   (rst),
    .push  (blk_push),
    .wdata (blk_wdata),
    .full  (blk_full),
    .pop   (blk_pop),
    .rdata (blk_rdata),
    .empty (blk_empty),
    .count (blk_count)
  );

  hcbe_back #(
    .BLOCK_LEN (BLOCK_LEN),
    .COEF_BITS (COEF_BITS),
    .OUT_DEPTH (OUT_Q_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .blk_empty (blk_empty || (blk_count == '0)),
    .blk_data  (blk_rdata),
    .blk_pop   (blk_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_data  (out_wdata)
  );

  hcbe_fifo #(
    .WIDTH(LETTER_W + 1),
    .DEPTH(OUT_Q_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wdata),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty),
    .count (out_count)
  );

  assign cipher_letter = out_rdata[LETTER_W-1:0];
  assign block_end     = out_rdata[LETTER_W] && !out_full || out_rdata[LETTER_W];

endmodule

>>> rtl/hcbe_fifo.sv
module hcbe_fifo
  import hcbe_pkg::*;
#(
  parameter int WIDTH = LETTER_W,
  parameter int DEPTH = OUT_Q_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

>>> rtl/hcbe_front.sv
module hcbe_front
  import hcbe_pkg::*;
#(
  parameter int BLOCK_LEN = BLOCK_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [LETTER_W-1:0]           plain_letter,
  output logic                          blk_push,
  output logic [BLOCK_LEN*LETTER_W-1:0] blk_data,
  input  logic                          blk_full
);

  localparam int FILL_W = $clog2(BLOCK_LEN);

  logic [LETTER_W-1:0] letter_buffer [BLOCK_LEN];
  logic [FILL_W-1:0]   fill_count;
  logic                last_slot;
  logic                take;

  assign last_slot = (fill_count == FILL_W'(BLOCK_LEN - 1));
  assign full      = last_slot && blk_full;
  assign take      = push && !full;
  assign blk_push  = take && last_slot;

  // The final letter goes straight into the block; earlier ones come from the buffer.
  always_comb begin
    for (int j = 0; j < BLOCK_LEN - 1; j++) begin
      blk_data[j*LETTER_W +: LETTER_W] = letter_buffer[j];
    end
    blk_data[(BLOCK_LEN-1)*LETTER_W +: LETTER_W] = plain_letter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (take) begin
      fill_count <= last_slot ? '0 : fill_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      letter_buffer[fill_count] <= plain_letter;
    end
  end

endmodule

>>> rtl/hcbe_back.sv
module hcbe_back
  import hcbe_pkg::*;
#(
  parameter int BLOCK_LEN   = BLOCK_LEN_DEF,
  parameter int COEF_BITS   = COEF_BITS_DEF,
  parameter int OUT_DEPTH   = OUT_Q_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [BLOCK_LEN*COEF_BITS-1:0] cfg_data,
  input  logic                           blk_empty,
  input  logic [BLOCK_LEN*LETTER_W-1:0]  blk_data,
  output logic                           blk_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           out_push,
  output logic [LETTER_W:0]              out_data
);

  localparam int ROW_BITS = BLOCK_LEN * COEF_BITS;
  localparam int ROW_W    = $clog2(BLOCK_LEN);
  localparam int COL_W    = $clog2(BLOCK_LEN);
  localparam int PROD_W   = COEF_BITS + LETTER_W;
  localparam int CRED_W   = $clog2(OUT_DEPTH + 5);
  localparam int SCALED_W = SUM_W + RECIP_W;
  localparam int DIFF_W   = SUM_W + 1;
  localparam int REM_W    = LETTER_W + 1;

  logic [ROW_BITS-1:0] key_row [BLOCK_LEN];
  logic [COL_W-1:0]    col;
  logic                issue;
  logic                credit_ok;
  logic                last_col;

  logic              s1_valid;
  logic              s1_last;
  logic [PROD_W-1:0] s1_prod [BLOCK_LEN];
  logic              s2_valid;
  logic              s2_last;
  logic [SUM_W-1:0]  s2_sum;
  logic              s3_valid;
  logic              s3_last;
  logic [SUM_W-1:0]  s3_sum;
  logic [QUO_W-1:0]  s3_quo;

  logic [SUM_W-1:0]    sum_next;
  logic [SCALED_W-1:0] scaled;
  logic [DIFF_W-1:0]   diff;
  logic [REM_W-1:0]    rem;
  logic [LETTER_W-1:0] letter;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < BLOCK_LEN; r++) begin
        key_row[r] <= ROW_BITS'(reset_row(r, COEF_BITS));
      end
    end else if (cfg_valid && ({1'b0, cfg_index} < (CFG_IDX_W+1)'(BLOCK_LEN))) begin
      key_row[cfg_index[ROW_W-1:0]] <= cfg_data;
    end
  end

  // An item is started only when the result queue has room for it and everything in flight.
  assign credit_ok = (CRED_W'(out_count) + CRED_W'(s1_valid) + CRED_W'(s2_valid)
                      + CRED_W'(s3_valid) + CRED_W'(1)) <= CRED_W'(OUT_DEPTH);
  assign issue     = !blk_empty && credit_ok;
  assign last_col  = (col == COL_W'(BLOCK_LEN - 1));
  assign blk_pop   = issue && last_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (issue) begin
        col <= last_col ? '0 : col + 1'b1;
      end
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_last <= last_col;
    for (int j = 0; j < BLOCK_LEN; j++) begin
      s1_prod[j] <= PROD_W'(key_row[j][col*COEF_BITS +: COEF_BITS])
                  * PROD_W'(blk_data[j*LETTER_W +: LETTER_W]);
    end
  end

  always_comb begin
    sum_next = '0;
    for (int j = 0; j < BLOCK_LEN; j++) begin
      sum_next = sum_next + SUM_W'(s1_prod[j]);
    end
  end

  always_ff @(posedge clk) begin
    s2_sum  <= sum_next;
    s2_last <= s1_last;
  end

  assign scaled = SCALED_W'(s2_sum) * SCALED_W'(RECIP);

  always_ff @(posedge clk) begin
    s3_sum  <= s2_sum;
    s3_quo  <= scaled[RECIP_SHIFT +: QUO_W];
    s3_last <= s2_last;
  end

  // The quotient estimate is at most one short, so one correction finishes the reduction.
  assign diff   = DIFF_W'(s3_sum) - DIFF_W'(s3_quo) * DIFF_W'(MODULUS);
  assign rem    = diff[REM_W-1:0];
  assign letter = (rem >= REM_W'(MODULUS)) ? LETTER_W'(rem - REM_W'(MODULUS))
                                           : LETTER_W'(rem);

  assign out_push = s3_valid;
  assign out_data = {s3_last, letter};

endmodule

>>> tb/testbench.sv
module testbench;
  import hcbe_pkg::*;

  localparam int NUM_ROWS = BLOCK_LEN_DEF;
  localparam int COEF_W   = COEF_BITS_DEF;
  localparam int ROW_W    = NUM_ROWS * COEF_W;
  localparam int DRAIN    = 16;
  localparam int PHASES   = 5;
  localparam int PHASE_N  = 41;

  typedef enum logic [CFG_IDX_W-1:0] {KEY_ROW0, KEY_ROW1, KEY_ROW2, KEY_ROW3} key_reg_t;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                last;
  } cipher_t;

  typedef struct packed {
    logic [0:3][LETTER_W-1:0] letters;
    logic                     typed;
    logic [0:3][LETTER_W-1:0] want;
  } dir_block_t;

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  logic [LETTER_W-1:0]  plain_letter;
  logic                 empty;
  logic                 pop;
  logic [LETTER_W-1:0]  cipher_letter;
  logic                 block_end;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ROW_W-1:0]     cfg_data;

  logic [COEF_W-1:0]   key_coef [NUM_ROWS][NUM_ROWS];
  logic [LETTER_W-1:0] plain_buf [NUM_ROWS];
  int                  fill;
  cipher_t             cipher_q [$];
  dir_block_t          typed_q [$];
  cipher_t             want_c;
  int                  err_count = 0;
  bit                  no_idle = 0;

  // Plain-letter blocks; where typed is set the cipher letters can be read off the key.
  dir_block_t dir_tbl [6] = '{
    '{'{5'd0, 5'd0, 5'd0, 5'd0},    1'b1, '{5'd0, 5'd0, 5'd0, 5'd0}},
    '{'{5'd1, 5'd0, 5'd0, 5'd0},    1'b1, '{5'd1, 5'd6, 5'd4, 5'd8}},
    '{'{5'd0, 5'd1, 5'd0, 5'd0},    1'b1, '{5'd2, 5'd1, 5'd21, 5'd19}},
    '{'{5'd0, 5'd0, 5'd1, 5'd0},    1'b1, '{5'd7, 5'd11, 5'd13, 5'd17}},
    '{'{5'd0, 5'd0, 5'd0, 5'd1},    1'b1, '{5'd3, 5'd5, 5'd23, 5'd3}},
    '{'{5'd25, 5'd26, 5'd30, 5'd31}, 1'b0, '{5'd0, 5'd0, 5'd0, 5'd0}}
  };

  hill_cipher_block_encrypt dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .plain_letter (plain_letter),
    .empty        (empty),
    .pop          (pop),
    .cipher_letter(cipher_letter),
    .block_end    (block_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    err_count++;
  endtask

  function automatic void absorb_letter(input logic [LETTER_W-1:0] letter);
    int         sum;
    dir_block_t tv;
    cipher_t    cv;
    plain_buf[fill] = letter;
    fill++;
    if (fill == NUM_ROWS) begin
      fill = 0;
      tv = '0;
      if (typed_q.size() != 0) begin
        tv = typed_q.pop_front();
      end
      for (int i = 0; i < NUM_ROWS; i++) begin
        sum = 0;
        for (int j = 0; j < NUM_ROWS; j++) begin
          sum += int'(key_coef[j][i]) * int'(plain_buf[j]);
        end
        cv.letter = tv.typed ? tv.want[i] : LETTER_W'(sum % MODULUS);
        cv.last   = (i == NUM_ROWS - 1);
        cipher_q  = {cipher_q, cv};
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < NUM_ROWS; c++) begin
          key_coef[r][c] = COEF_W'(RESET_KEY[r][c]);
        end
      end
      fill = 0;
    end else begin
      if (pop && !empty) begin
        if (cipher_q.size() == 0) begin
          report_mismatch("unexpected cipher_letter", cipher_letter, -1);
        end else begin
          want_c = cipher_q.pop_front();
          if (cipher_letter !== want_c.letter) begin
            report_mismatch("cipher_letter", cipher_letter, want_c.letter);
          end
          if (block_end !== want_c.last) begin
            report_mismatch("block_end", block_end, want_c.last);
          end
        end
      end
      if (cfg_valid && cfg_ready && cfg_index < NUM_ROWS) begin
        for (int c = 0; c < NUM_ROWS; c++) begin
          key_coef[cfg_index][c] = cfg_data[c*COEF_W +: COEF_W];
        end
      end
      if (push && !full) begin
        absorb_letter(plain_letter);
      end
    end
  end

  initial begin
    pop = 1'b0;
    @(negedge rst);
    forever begin
      if (no_idle) begin
        pop <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic send_letter(input logic [LETTER_W-1:0] v);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    push         <= 1'b1;
    plain_letter <= v;
    do @(posedge clk); while (full);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic load_key(input logic [ROW_W-1:0] rows [NUM_ROWS]);
    for (int k = KEY_ROW0; k <= KEY_ROW3 + 1; k++) begin
      cfg_valid <= 1'b1;
      if (k <= KEY_ROW3) begin
        cfg_index <= CFG_IDX_W'(k);
        cfg_data  <= rows[k];
      end else begin
        // Indexes past the key rows must leave the key alone.
        cfg_index <= CFG_IDX_W'($urandom_range(KEY_ROW3 + 1, 2**CFG_IDX_W - 1));
        cfg_data  <= ROW_W'($urandom);
      end
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [ROW_W-1:0] rows [NUM_ROWS];
    rst          = 1'b1;
    push         = 1'b0;
    plain_letter = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tbl[b]) begin
      typed_q = {typed_q, dir_tbl[b]};
      for (int i = 0; i < NUM_ROWS; i++) begin
        send_letter(dir_tbl[b].letters[i]);
      end
    end
    // A partial block must stay buffered with nothing coming out.
    send_letter(5'd25);
    send_letter(5'd13);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain_results();
        for (int r = 0; r < NUM_ROWS; r++) begin
          case (p)
            2:       rows[r] = '0;
            3:       rows[r] = '1;
            default: rows[r] = ROW_W'($urandom);
          endcase
        end
        load_key(rows);
      end
      no_idle = (p == PHASES - 1);
      for (int n = 0; n < PHASE_N; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_letter(LETTER_W'($urandom_range(0, 31)));
        end else begin
          send_letter(LETTER_W'($urandom_range(0, MODULUS - 1)));
        end
      end
    end

    drain_results();
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

endmodule
